>>> src/window_average_pooling_assert.svh
// Assertion macros for the pooling RTL.
// Each macro takes a label, the clock, the active-low reset, the antecedent,
// the consequent and a message.
`ifndef WINDOW_AVERAGE_POOLING_ASSERT_SVH
`define WINDOW_AVERAGE_POOLING_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define WAP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define WAP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/wap_pkg.sv
`timescale 1ns / 1ps

package wap_pkg;

	localparam int PIXEL_W          = 8;
	localparam int PIXEL_FULL       = 255;
	localparam int WIN_CFG_W        = 5;
	localparam int IMG_CFG_W        = 11;
	localparam int CFG_DATA_W       = 11;
	localparam int CFG_IDX_W        = 2;
	localparam int FEAT_W           = 10;
	localparam int MAX_IMAGE_HEIGHT = 1024;
	localparam int ROW_W            = $clog2(MAX_IMAGE_HEIGHT);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_HEIGHT = 2'd0,
		REG_WINDOW_WIDTH  = 2'd1,
		REG_IMAGE_WIDTH   = 2'd2,
		REG_IMAGE_HEIGHT  = 2'd3
	} cfg_reg_t;

	// Position status of the pixel currently offered at the input.
	typedef struct packed {
		logic active;
		logic col_end;
		logic row_first;
		logic row_last;
		logic last_win;
	} pos_flags_t;

	// Coordinates carried alongside a window sum down to the output.
	typedef struct packed {
		logic [FEAT_W-1:0] row;
		logic [FEAT_W-1:0] col;
		logic              last;
	} feat_meta_t;

endpackage

>>> src/wap_ram.sv
`timescale 1ns / 1ps

module wap_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> src/wap_recip.sv
`timescale 1ns / 1ps

// Bit-serial restoring division of 2^NUM_EXP by the divisor, one quotient
// bit per cycle, most significant first.
module wap_recip #(
	parameter int NUM_EXP = 32,
	parameter int DEN_W   = 16,
	parameter int QUO_W   = 25
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DEN_W-1:0] divisor,
	output logic             busy,
	output logic [QUO_W-1:0] quotient
);

	localparam int CNT_W = $clog2(NUM_EXP + 1);

	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [QUO_W-1:0] quo_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	// The numerator has a single set bit, which enters on the first step.
	assign trial = {rem_q, (cnt_q == '0)};
	assign diff  = trial - {1'b0, divisor};
	assign ge    = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			rem_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(NUM_EXP)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && !start) begin
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

>>> src/wap_pos.sv
`timescale 1ns / 1ps

module wap_pos
	import wap_pkg::*;
#(
	parameter int COL_W = 10,
	parameter int WIN_W = 5,
	parameter int CW_W  = 4,
	parameter int SUM_W = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               restart,
	input  logic               step,
	input  logic [PIXEL_W-1:0] pixel,
	input  logic [WIN_W-1:0]   wh,
	input  logic [WIN_W-1:0]   ww,
	input  logic [COL_W:0]     iw,
	input  logic [ROW_W:0]     ih,
	output pos_flags_t         flags,
	output logic [COL_W-1:0]   win_col,
	output logic [ROW_W-1:0]   win_row,
	output logic [SUM_W-1:0]   acc
);

	localparam int CCMP_W = COL_W + 2;
	localparam int RCMP_W = ROW_W + 2;

	logic [COL_W-1:0] col_q, fc_q, col_start_q;
	logic [ROW_W-1:0] row_q, fr_q, row_start_q;
	logic [CW_W-1:0]  cw_q, rw_q;
	logic [SUM_W-1:0] run_q;

	logic [WIN_W-1:0] ww_m1, wh_m1;
	logic             col_fit, row_fit, col_final, row_final;
	logic             cw_wrap, rw_wrap, col_wrap, row_wrap;

	assign ww_m1 = ww - WIN_W'(1);
	assign wh_m1 = wh - WIN_W'(1);

	// A window is whole when it ends inside the image; it is the last one
	// along an axis when a further window would not fit.
	assign col_fit   = (CCMP_W'(col_start_q) + CCMP_W'(ww)) <= CCMP_W'(iw);
	assign row_fit   = (RCMP_W'(row_start_q) + RCMP_W'(wh)) <= RCMP_W'(ih);
	assign col_final = (CCMP_W'(col_start_q) + CCMP_W'(ww) + CCMP_W'(ww)) > CCMP_W'(iw);
	assign row_final = (RCMP_W'(row_start_q) + RCMP_W'(wh) + RCMP_W'(wh)) > RCMP_W'(ih);

	assign cw_wrap  = (WIN_W'(cw_q) + WIN_W'(1)) >= ww;
	assign rw_wrap  = (WIN_W'(rw_q) + WIN_W'(1)) >= wh;
	assign col_wrap = ({1'b0, col_q} + (COL_W+1)'(1)) >= iw;
	assign row_wrap = ({1'b0, row_q} + (ROW_W+1)'(1)) >= ih;

	assign flags.active    = col_fit && row_fit;
	assign flags.col_end   = cw_q == CW_W'(ww_m1);
	assign flags.row_first = rw_q == '0;
	assign flags.row_last  = rw_q == CW_W'(wh_m1);
	assign flags.last_win  = col_final && row_final;

	assign win_col = fc_q;
	assign win_row = fr_q;
	assign acc     = run_q + SUM_W'(pixel);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			fc_q        <= '0;
			col_start_q <= '0;
			cw_q        <= '0;
			row_q       <= '0;
			fr_q        <= '0;
			row_start_q <= '0;
			rw_q        <= '0;
			run_q       <= '0;
		end else if (restart) begin
			col_q       <= '0;
			fc_q        <= '0;
			col_start_q <= '0;
			cw_q        <= '0;
			row_q       <= '0;
			fr_q        <= '0;
			row_start_q <= '0;
			rw_q        <= '0;
			run_q       <= '0;
		end else if (step) begin
			if (flags.active) begin
				run_q <= flags.col_end ? '0 : acc;
			end
			if (col_wrap) begin
				col_q       <= '0;
				cw_q        <= '0;
				fc_q        <= '0;
				col_start_q <= '0;
				run_q       <= '0;
				if (row_wrap) begin
					row_q       <= '0;
					rw_q        <= '0;
					fr_q        <= '0;
					row_start_q <= '0;
				end else begin
					row_q <= row_q + ROW_W'(1);
					if (rw_wrap) begin
						rw_q        <= '0;
						fr_q        <= fr_q + ROW_W'(1);
						row_start_q <= row_q + ROW_W'(1);
					end else begin
						rw_q <= rw_q + CW_W'(1);
					end
				end
			end else begin
				col_q <= col_q + COL_W'(1);
				if (cw_wrap) begin
					cw_q        <= '0;
					fc_q        <= fc_q + COL_W'(1);
					col_start_q <= col_q + COL_W'(1);
				end else begin
					cw_q <= cw_q + CW_W'(1);
				end
			end
		end
	end

endmodule

>>> src/wap_scale.sv
`timescale 1ns / 1ps

// Scales a window sum by the stored reciprocal of 255*h*w, corrects the
// truncated estimate by one and holds the result for the output request.
module wap_scale
	import wap_pkg::*;
#(
	parameter int SUM_W  = 16,
	parameter int R_W    = 25,
	parameter int FRAC_W = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              emit,
	input  logic [SUM_W-1:0]  total,
	input  feat_meta_t        meta,
	input  logic [R_W-1:0]    recip,
	input  logic [SUM_W-1:0]  divisor,
	output logic              advance,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [FRAC_W:0]   feature_value,
	output logic [FEAT_W-1:0] feature_row,
	output logic [FEAT_W-1:0] feature_col,
	output logic              last_feature
);

	localparam int VAL_W  = FRAC_W + 1;
	localparam int PROD_W = SUM_W + R_W;
	localparam int CHK_W  = SUM_W + VAL_W;

	logic              emit_s2, emit_s3, emit_s4, out_valid_q;
	logic [SUM_W-1:0]  total_s2, total_s3, total_s4;
	feat_meta_t        meta_s2, meta_s3, meta_s4, meta_q;
	logic [PROD_W-1:0] prod_s3;
	logic [VAL_W-1:0]  q0_s4, value_q;
	logic [CHK_W-1:0]  chk_s4;

	logic [VAL_W-1:0]  q0, q1;
	logic [CHK_W-1:0]  thr;

	assign advance = !out_valid_q || out_ready;

	// The estimate is the true quotient or one below it.
	assign q0  = prod_s3[SUM_W +: VAL_W];
	assign q1  = q0 + VAL_W'(1);
	assign thr = CHK_W'(total_s4) << FRAC_W;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s2     <= 1'b0;
			emit_s3     <= 1'b0;
			emit_s4     <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			emit_s2     <= emit;
			emit_s3     <= emit_s2;
			emit_s4     <= emit_s3;
			out_valid_q <= emit_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			total_s2 <= total;
			meta_s2  <= meta;
			prod_s3  <= PROD_W'(total_s2) * PROD_W'(recip);
			total_s3 <= total_s2;
			meta_s3  <= meta_s2;
			q0_s4    <= q0;
			chk_s4   <= CHK_W'(q1) * CHK_W'(divisor);
			total_s4 <= total_s3;
			meta_s4  <= meta_s3;
			if (emit_s4) begin
				value_q <= q0_s4 + VAL_W'(chk_s4 <= thr);
				meta_q  <= meta_s4;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign feature_value = value_q;
	assign feature_row   = meta_q.row;
	assign feature_col   = meta_q.col;
	assign last_feature  = meta_q.last;

endmodule

>>> src/window_average_pooling.sv
// The pixel that completes a window moves through stage s1, stages s2 to s4 and the output register.
// Throughput: one pixel per cycle while the output request is taken; the pipeline
// stalls as a whole when the output register is full.
// After reset and after each configuration write, in_ready stays low while the serial
// divider forms 2^(SUM_W + FRACTION_BITS)/(255*h*w), 2^32 by default.
// Reset clears counters and control; the column sum memory needs no clearing pass.
`timescale 1ns / 1ps
`include "window_average_pooling_assert.svh"

module window_average_pooling
	import wap_pkg::*;
#(
	parameter int MAX_IMAGE_WIDTH = 1024,
	parameter int MAX_WINDOW      = 16,
	parameter int FRACTION_BITS   = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [PIXEL_W-1:0]    pixel,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [FRACTION_BITS:0] feature_value,
	output logic [FEAT_W-1:0]     feature_row,
	output logic [FEAT_W-1:0]     feature_col,
	output logic                  last_feature
);

	localparam int COL_W   = $clog2(MAX_IMAGE_WIDTH);
	localparam int IW_W    = COL_W + 1;
	localparam int IH_W    = ROW_W + 1;
	localparam int WIN_W   = $clog2(MAX_WINDOW + 1);
	localparam int CW_W    = $clog2(MAX_WINDOW);
	localparam int SUM_W   = $clog2(PIXEL_FULL * MAX_WINDOW * MAX_WINDOW + 1);
	localparam int K_W     = SUM_W + FRACTION_BITS;
	localparam int R_W     = K_W - ($clog2(PIXEL_FULL + 1) - 1);
	localparam int VAL_W   = FRACTION_BITS + 1;
	localparam int WIN_RST = 2;
	localparam int IW_RST  = (MAX_IMAGE_WIDTH < 1024) ? MAX_IMAGE_WIDTH : 1024;
	localparam int IH_RST  = (MAX_IMAGE_HEIGHT < 1024) ? MAX_IMAGE_HEIGHT : 1024;
	localparam logic [VAL_W-1:0] VAL_ONE = VAL_W'(1) << FRACTION_BITS;

	logic                 cfg_accept, accept, advance;
	logic [WIN_W-1:0]     wh_q, ww_q, win_clamped;
	logic [IW_W-1:0]      iw_q, iw_clamped;
	logic [IH_W-1:0]      ih_q, ih_clamped;
	logic [WIN_CFG_W-1:0] win_cfg;
	logic [IMG_CFG_W-1:0] img_cfg;
	logic                 start_q, recip_busy;
	logic [2*WIN_W-1:0]   win_area;
	logic [SUM_W-1:0]     divisor_d, divisor_q;
	logic [R_W-1:0]       recip;

	pos_flags_t           flags;
	logic [COL_W-1:0]     win_col;
	logic [ROW_W-1:0]     win_row;
	logic [SUM_W-1:0]     acc;

	logic                 ram_we, ram_re;
	logic [COL_W-1:0]     ram_waddr, ram_raddr;
	logic [SUM_W-1:0]     ram_wdata, ram_rdata;

	logic                 wr_s1, emit_s1, first_s1, fwd_s1;
	logic [COL_W-1:0]     slot_s1;
	logic [SUM_W-1:0]     acc_s1, fwd_data_s1;
	feat_meta_t           meta_s1;
	logic [SUM_W-1:0]     old_sum, total;

	assign cfg_ready  = 1'b1;
	assign cfg_accept = cfg_valid && cfg_ready;

	// Out-of-range sizes: zero acts as one, larger values saturate.
	assign win_cfg = cfg_data[WIN_CFG_W-1:0];
	assign img_cfg = cfg_data[IMG_CFG_W-1:0];

	always_comb begin
		if (win_cfg == '0) begin
			win_clamped = WIN_W'(1);
		end else if (int'(win_cfg) > MAX_WINDOW) begin
			win_clamped = WIN_W'(MAX_WINDOW);
		end else begin
			win_clamped = WIN_W'(win_cfg);
		end
		if (img_cfg == '0) begin
			iw_clamped = IW_W'(1);
			ih_clamped = IH_W'(1);
		end else begin
			iw_clamped = (int'(img_cfg) > MAX_IMAGE_WIDTH) ? IW_W'(MAX_IMAGE_WIDTH)
				: IW_W'(img_cfg);
			ih_clamped = (int'(img_cfg) > MAX_IMAGE_HEIGHT) ? IH_W'(MAX_IMAGE_HEIGHT)
				: IH_W'(img_cfg);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wh_q <= WIN_W'(WIN_RST);
			ww_q <= WIN_W'(WIN_RST);
			iw_q <= IW_W'(IW_RST);
			ih_q <= IH_W'(IH_RST);
		end else if (cfg_accept) begin
			case (cfg_reg_t'(cfg_index))
				REG_WINDOW_HEIGHT: begin
					wh_q <= win_clamped;
				end
				REG_WINDOW_WIDTH: begin
					ww_q <= win_clamped;
				end
				REG_IMAGE_WIDTH: begin
					iw_q <= iw_clamped;
				end
				REG_IMAGE_HEIGHT: begin
					ih_q <= ih_clamped;
				end
				default: begin
				end
			endcase
		end
	end

	// The divider restarts in the cycle after a write, once the divisor register
	// has taken the new window size.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b1;
		end else begin
			start_q <= cfg_accept;
		end
	end

	assign win_area  = (2*WIN_W)'(wh_q) * (2*WIN_W)'(ww_q);
	assign divisor_d = SUM_W'(win_area) * SUM_W'(PIXEL_FULL);

	always_ff @(posedge clk) begin
		divisor_q <= divisor_d;
	end

	wap_recip #(
		.NUM_EXP (K_W),
		.DEN_W   (SUM_W),
		.QUO_W   (R_W)
	) u_recip (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.divisor  (divisor_q),
		.busy     (recip_busy),
		.quotient (recip)
	);

	assign in_ready = advance && !recip_busy && !start_q;
	assign accept   = in_valid && in_ready;

	wap_pos #(
		.COL_W (COL_W),
		.WIN_W (WIN_W),
		.CW_W  (CW_W),
		.SUM_W (SUM_W)
	) u_pos (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (cfg_accept),
		.step    (accept),
		.pixel   (pixel),
		.wh      (wh_q),
		.ww      (ww_q),
		.iw      (iw_q),
		.ih      (ih_q),
		.flags   (flags),
		.win_col (win_col),
		.win_row (win_row),
		.acc     (acc)
	);

	// Column sums: read when a pixel closes its window column and written back
	// from stage s1 when the pipeline advances. Every slot is zeroed by the last
	// row of a window row, so the first row of each window row treats the stored
	// value as zero and the memory never needs clearing.
	assign ram_re    = accept && flags.active && flags.col_end;
	assign ram_raddr = win_col;
	assign ram_we    = advance && wr_s1;
	assign ram_waddr = slot_s1;
	assign ram_wdata = emit_s1 ? '0 : total;

	wap_ram #(
		.WIDTH (SUM_W),
		.DEPTH (MAX_IMAGE_WIDTH)
	) u_col_sums (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s1   <= 1'b0;
			emit_s1 <= 1'b0;
		end else if (advance) begin
			wr_s1   <= ram_re;
			emit_s1 <= ram_re && flags.row_last;
		end
	end

	// A write landing on the slot being read in the same cycle is forwarded,
	// since the memory returns the old contents.
	always_ff @(posedge clk) begin
		if (accept) begin
			slot_s1     <= win_col;
			acc_s1      <= acc;
			first_s1    <= flags.row_first;
			meta_s1     <= '{row: FEAT_W'(win_row), col: FEAT_W'(win_col),
				last: flags.last_win};
			fwd_s1      <= ram_we && (ram_waddr == win_col);
			fwd_data_s1 <= ram_wdata;
		end
	end

	assign old_sum = first_s1 ? '0 : (fwd_s1 ? fwd_data_s1 : ram_rdata);
	assign total   = old_sum + acc_s1;

	wap_scale #(
		.SUM_W  (SUM_W),
		.R_W    (R_W),
		.FRAC_W (FRACTION_BITS)
	) u_scale (
		.clk           (clk),
		.arst_n        (arst_n),
		.emit          (emit_s1),
		.total         (total),
		.meta          (meta_s1),
		.recip         (recip),
		.divisor       (divisor_q),
		.advance       (advance),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.feature_value (feature_value),
		.feature_row   (feature_row),
		.feature_col   (feature_col),
		.last_feature  (last_feature)
	);

	`WAP_ASSERT_NOW(a_value_range, clk, arst_n, out_valid, feature_value <= VAL_ONE, "feature value above one")
	`WAP_ASSERT_NEXT(a_cfg_blocks_input, clk, arst_n, cfg_accept, !in_ready, "pixel taken right after a configuration write")
	`WAP_ASSERT_NEXT(a_read_then_write, clk, arst_n, ram_re && advance, wr_s1, "column sum read without write-back")

endmodule
